// ===== sv/iis_pkg.sv =====
// Shared types and constants for the integral image block.
package iis_pkg;

    // Default line length the line memory is sized for
    localparam int MAX_WIDTH_DEF = 4096;

    // Field widths fixed by the interface
    localparam int PIX_W   = 8;
    localparam int SUM_W   = 32;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_SIGNED_PIXELS = 2'd1
    } iis_cfg_idx_t;

    // Row state handed from the row accumulator to the line-memory stage
    typedef struct packed {
        logic             first_row;
        logic [SUM_W-1:0] row_sum;
        logic [SUM_W-1:0] row_sq;
    } iis_row_t;

endpackage

// ===== sv/iis_line_mem.sv =====
// Line memory holding the previous row's integral totals, one read and one write port.
module iis_line_mem
    import iis_pkg::*;
#(
    parameter int DEPTH  = MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(MAX_WIDTH_DEF),
    parameter int DATA_W = 2 * SUM_W
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write the updated totals
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold the data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/iis_row_acc.sv =====
// Column tracking and running row sums for each accepted pixel.
module iis_row_acc
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [PIX_W-1:0] pixel,
    input  logic             frame_start,
    input  logic [CFG_W-1:0] image_width,
    input  logic             signed_pixels,
    output logic [COL_W-1:0] cur_col,
    output iis_row_t         row_out
);

    localparam int WID_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    logic [COL_W-1:0] col_reg, col_next;
    logic [SUM_W-1:0] row_sum_reg, row_sum_next;
    logic [SUM_W-1:0] row_sq_reg, row_sq_next;
    logic             first_reg, first_next;

    logic [WID_W-1:0] cfg_ext;
    logic [WID_W-1:0] eff_width;
    logic             restart_row;
    logic             restart;
    logic             first_cur;
    logic             neg;
    logic [SUM_W-1:0] value;
    logic [PIX_W:0]   mag;
    logic [2*PIX_W+1:0] mag_sq;
    logic [SUM_W-1:0] sum_new;
    logic [SUM_W-1:0] sq_new;
    logic [WID_W-1:0] col_inc;
    logic             wrap;

    // Clamp the programmed width into 1..MAX_WIDTH
    always_comb
    begin
        cfg_ext = WID_W'(image_width);
        if (cfg_ext == '0)
        begin
            eff_width = WID_W'(1);
        end
        else if (cfg_ext > WID_W'(MAX_WIDTH))
        begin
            eff_width = WID_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = cfg_ext;
        end
    end

    // Resolve row and frame restarts, then accumulate the pixel
    always_comb
    begin
        restart_row = !frame_start && (WID_W'(col_reg) >= eff_width);
        restart     = frame_start || restart_row;
        cur_col     = restart ? '0 : col_reg;
        first_cur   = frame_start ? 1'b1 : (restart_row ? 1'b0 : first_reg);

        neg   = signed_pixels && pixel[PIX_W-1];
        value = neg ? {{(SUM_W-PIX_W){1'b1}}, pixel} : {{(SUM_W-PIX_W){1'b0}}, pixel};
        mag   = neg ? ((PIX_W+1)'(1 << PIX_W) - {1'b0, pixel}) : {1'b0, pixel};
        mag_sq = mag * mag;

        sum_new = (restart ? '0 : row_sum_reg) + value;
        sq_new  = (restart ? '0 : row_sq_reg) + SUM_W'(mag_sq);

        col_inc = WID_W'(cur_col) + WID_W'(1);
        wrap    = col_inc >= eff_width;

        if (wrap)
        begin
            col_next     = '0;
            row_sum_next = '0;
            row_sq_next  = '0;
            first_next   = 1'b0;
        end
        else
        begin
            col_next     = col_inc[COL_W-1:0];
            row_sum_next = sum_new;
            row_sq_next  = sq_new;
            first_next   = first_cur;
        end

        row_out.first_row = first_cur;
        row_out.row_sum   = sum_new;
        row_out.row_sq    = sq_new;
    end

    // Advance the row state on each accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_sum_reg <= '0;
            row_sq_reg  <= '0;
            first_reg   <= 1'b1;
        end
        else if (accept)
        begin
            col_reg     <= col_next;
            row_sum_reg <= row_sum_next;
            row_sq_reg  <= row_sq_next;
            first_reg   <= first_next;
        end
    end

endmodule

// ===== sv/integral_image_with_square_sum.sv =====
// An accepted pixel is registered in stage one, then in the output register that drives m_tvalid.
// One pixel per clock unless m_tready stalls; each does one line-memory read-modify-write.
// A same-column write still in flight is forwarded to the next read (image width of one).
// Reset clears the row state, the pipeline valids and the configuration (width 4096, unsigned).
// The line memory is not cleared; the first row of every frame ignores what it reads.
// Configuration writes are always taken (cfg_ready high).
module integral_image_with_square_sum
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Pixel requests
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,   // [7:0] pixel
    input  logic                 s_tuser,   // [0] frame_start
    // Integral results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*SUM_W-1:0]   m_tdata,   // [31:0] area_sum, [63:32] area_square_sum
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0]   width_reg;
    logic               signed_reg;

    logic               accept;
    logic [COL_W-1:0]   cur_col;
    iis_row_t           row_cur;

    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    iis_row_t           s1_row_reg;
    logic               fwd_hit_reg;
    logic [2*SUM_W-1:0] fwd_data_reg;
    logic               s1_adv;

    logic [2*SUM_W-1:0] rd_data;
    logic [2*SUM_W-1:0] up_data;
    logic [SUM_W-1:0]   total;
    logic [SUM_W-1:0]   total_sq;

    logic               out_valid_reg;
    logic [2*SUM_W-1:0] out_data_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(4096);
            signed_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                CFG_SIGNED_PIXELS: signed_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Handshake: stage one frees up when the output register can take its result
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    iis_row_acc #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_row_acc (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .pixel         (s_tdata),
        .frame_start   (s_tuser),
        .image_width   (width_reg),
        .signed_pixels (signed_reg),
        .cur_col       (cur_col),
        .row_out       (row_cur)
    );

    iis_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (2 * SUM_W)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({total_sq, total})
    );

    // Add the above-row totals; take the forwarded write when it hit this column
    always_comb
    begin
        if (s1_row_reg.first_row)
        begin
            up_data = '0;
        end
        else if (fwd_hit_reg)
        begin
            up_data = fwd_data_reg;
        end
        else
        begin
            up_data = rd_data;
        end
        total    = s1_row_reg.row_sum + up_data[SUM_W-1:0];
        total_sq = s1_row_reg.row_sq + up_data[2*SUM_W-1:SUM_W];
    end

    // Stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            fwd_hit_reg  <= s1_valid_reg && (s1_col_reg == cur_col);
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage one payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= cur_col;
            s1_row_reg   <= row_cur;
            fwd_data_reg <= {total_sq, total};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= {total_sq, total};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Every accepted pixel occupies stage one in the next cycle
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel did not reach stage one");

    // A result appears only after stage one held an item
    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s1_valid_reg))
        else $error("result without a stage one item");

    // A stalled stage one keeps its column so the write-back address stays put
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("stalled stage one lost its column");

    // No new read is issued while stage one is stuck
    a_no_read_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> !accept)
        else $error("pixel accepted over a stalled stage one");

endmodule
